// ----- design/stc_pkg.sv -----
`timescale 1ns / 1ps

package stc_pkg;

    // character codes
    localparam logic [7:0] CHR_BLANK = 8'd32;
    localparam logic [7:0] CHR_TAB   = 8'd9;

    // field widths
    localparam int CHAR_W = 8;
    localparam int TW_W   = 5;

    // tab width register
    localparam logic [TW_W-1:0] TAB_WIDTH_RESET = 5'd8;
    localparam int MIN_TAB_WIDTH     = 2;
    localparam int MAX_TAB_WIDTH_DEF = 16;

    // command queue depth between front and back
    localparam int CMDQ_DEPTH = 2;

endpackage

// ----- design/stc_if.sv -----
`timescale 1ns / 1ps

// input characters
interface stc_in_if;
    logic                          valid;
    logic                          ready;
    logic [stc_pkg::CHAR_W-1:0]    in_char;
    logic                          line_end;

    modport source (output valid, output in_char, output line_end, input ready);
    modport sink   (input valid, input in_char, input line_end, output ready);
endinterface

// output characters
interface stc_out_if;
    logic                          valid;
    logic                          ready;
    logic [stc_pkg::CHAR_W-1:0]    out_char;
    logic                          run_last;

    modport source (output valid, output out_char, output run_last, input ready);
    modport sink   (input valid, input out_char, input run_last, output ready);
endinterface

// tab width register writes
interface stc_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [stc_pkg::TW_W-1:0]      tab_width;

    modport source (output valid, output tab_width, input ready);
    modport sink   (input valid, input tab_width, output ready);
endinterface

// ----- design/stc_front.sv -----
`timescale 1ns / 1ps

module stc_front #(
    parameter int MAX_TAB_WIDTH = stc_pkg::MAX_TAB_WIDTH_DEF,
    parameter int CNT_W         = $clog2(MAX_TAB_WIDTH),
    parameter int CMD_W         = CNT_W + 1 + stc_pkg::CHAR_W
) (
    input  logic              clk,
    input  logic              rst_n,
    stc_in_if.sink            in,
    stc_cfg_if.sink           cfg,
    output logic              push_valid,
    output logic [CMD_W-1:0]  push_data,
    input  logic              push_ready
);

    localparam int LIM_W = $clog2(MAX_TAB_WIDTH + 1);
    localparam int CMP_W = (stc_pkg::TW_W > LIM_W) ? stc_pkg::TW_W : LIM_W;

    logic [stc_pkg::TW_W-1:0]   tab_width_reg;
    logic [CNT_W-1:0]           column_reg;
    logic [CNT_W-1:0]           column_next;
    logic [CNT_W-1:0]           pending_reg;
    logic [CNT_W-1:0]           pending_next;

    logic [CMP_W-1:0]           tw_ext;
    logic [CMP_W-1:0]           eff_width;
    logic [CMP_W-1:0]           col_inc;
    logic                       at_stop;
    logic                       is_blank;
    logic [CNT_W-1:0]           pend_inc;
    logic                       accept;
    logic                       produce;

    logic [CNT_W-1:0]           cmd_blanks;
    logic                       cmd_has_char;
    logic [stc_pkg::CHAR_W-1:0] cmd_char;

    // effective tab width, clamped to the supported range
    always_comb
    begin
        tw_ext = CMP_W'(tab_width_reg);
        if (tw_ext < CMP_W'(stc_pkg::MIN_TAB_WIDTH))
        begin
            eff_width = CMP_W'(stc_pkg::MIN_TAB_WIDTH);
        end
        else if (tw_ext > CMP_W'(MAX_TAB_WIDTH))
        begin
            eff_width = CMP_W'(MAX_TAB_WIDTH);
        end
        else
        begin
            eff_width = tw_ext;
        end
    end

    // column step and tab stop detection
    assign col_inc  = CMP_W'(column_reg) + CMP_W'(1);
    assign at_stop  = (col_inc >= eff_width);
    assign is_blank = (in.in_char == stc_pkg::CHR_BLANK);
    assign pend_inc = pending_reg + CNT_W'(1);

    // classify the character into a command for the back end
    always_comb
    begin
        cmd_blanks   = '0;
        cmd_has_char = 1'b0;
        cmd_char     = in.in_char;
        column_next  = column_reg;
        pending_next = pending_reg;
        if (is_blank)
        begin
            if (at_stop)
            begin
                cmd_has_char = 1'b1;
                cmd_char     = (pending_reg != '0) ? stc_pkg::CHR_TAB : stc_pkg::CHR_BLANK;
                column_next  = '0;
                pending_next = '0;
            end
            else
            begin
                column_next  = col_inc[CNT_W-1:0];
                pending_next = pend_inc;
                cmd_blanks   = pend_inc;
            end
        end
        else
        begin
            cmd_blanks   = pending_reg;
            cmd_has_char = 1'b1;
            column_next  = at_stop ? '0 : col_inc[CNT_W-1:0];
            pending_next = '0;
        end
        if (in.line_end)
        begin
            column_next  = '0;
            pending_next = '0;
        end
    end

    // a blank between stops that ends no line gives nothing
    assign produce    = !(is_blank && !at_stop && !in.line_end);
    assign in.ready   = push_ready;
    assign accept     = in.valid && push_ready;
    assign push_valid = accept && produce;
    assign push_data  = {cmd_blanks, cmd_has_char, cmd_char};
    assign cfg.ready  = 1'b1;

    // state and tab width register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tab_width_reg <= stc_pkg::TAB_WIDTH_RESET;
            column_reg    <= '0;
            pending_reg   <= '0;
        end
        else
        begin
            if (cfg.valid)
            begin
                tab_width_reg <= cfg.tab_width;
            end
            if (accept)
            begin
                column_reg  <= column_next;
                pending_reg <= pending_next;
            end
        end
    end

endmodule

// ----- design/stc_cmd_fifo.sv -----
`timescale 1ns / 1ps

module stc_cmd_fifo #(
    parameter int DATA_W = 13
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    input  logic [DATA_W-1:0] push_data,
    output logic              push_ready,
    output logic              head_valid,
    output logic [DATA_W-1:0] head_data,
    input  logic              pop
);

    localparam int PTR_W = $clog2(stc_pkg::CMDQ_DEPTH);
    localparam int CNT_W = $clog2(stc_pkg::CMDQ_DEPTH + 1);

    logic [DATA_W-1:0] entry_reg [stc_pkg::CMDQ_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != CNT_W'(stc_pkg::CMDQ_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && head_valid;

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(stc_pkg::CMDQ_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(stc_pkg::CMDQ_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (!do_push && do_pop)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

// ----- design/stc_back.sv -----
`timescale 1ns / 1ps

module stc_back #(
    parameter int MAX_TAB_WIDTH = stc_pkg::MAX_TAB_WIDTH_DEF,
    parameter int CNT_W         = $clog2(MAX_TAB_WIDTH),
    parameter int CMD_W         = CNT_W + 1 + stc_pkg::CHAR_W
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  logic [CMD_W-1:0]  head_data,
    output logic              pop,
    stc_out_if.source         out
);

    logic [CNT_W-1:0]           sent_reg;
    logic [CNT_W-1:0]           sent_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [stc_pkg::CHAR_W-1:0] out_char_reg;
    logic [stc_pkg::CHAR_W-1:0] out_char_next;
    logic                       run_last_reg;
    logic                       run_last_next;

    logic [CNT_W-1:0]           head_blanks;
    logic                       head_has_char;
    logic [stc_pkg::CHAR_W-1:0] head_char;
    logic                       load;
    logic                       emit;
    logic                       more_blanks;
    logic                       last_blank;

    assign {head_blanks, head_has_char, head_char} = head_data;

    assign load        = !out_valid_reg || out.ready;
    assign emit        = load && head_valid;
    assign more_blanks = (sent_reg < head_blanks);
    assign last_blank  = ((CNT_W + 1)'(sent_reg) + (CNT_W + 1)'(1)) ==
                         (CNT_W + 1)'(head_blanks);

    // expand the head command: pending blanks first, then the character
    always_comb
    begin
        sent_next      = sent_reg;
        out_char_next  = out_char_reg;
        run_last_next  = run_last_reg;
        pop            = 1'b0;
        if (emit)
        begin
            if (more_blanks)
            begin
                out_char_next = stc_pkg::CHR_BLANK;
                run_last_next = last_blank && !head_has_char;
                pop           = last_blank && !head_has_char;
                sent_next     = pop ? '0 : sent_reg + CNT_W'(1);
            end
            else
            begin
                out_char_next = head_char;
                run_last_next = 1'b1;
                pop           = 1'b1;
                sent_next     = '0;
            end
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out.valid    = out_valid_reg;
    assign out.out_char = out_char_reg;
    assign out.run_last = run_last_reg;

    // output register and blank counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sent_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sent_reg      <= sent_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        out_char_reg <= out_char_next;
        run_last_reg <= run_last_next;
    end

endmodule

// ----- design/space_run_to_tab_compressor.sv -----
`timescale 1ns / 1ps

// Space-run-to-tab compressor. Characters enter on "in" with line_end on the
// last one of a line; compressed text leaves on "out" one byte per ready cycle,
// with run_last marking the final byte caused by each input character. A run of
// blanks that reaches a tab stop becomes one tab (or one blank if the run is a
// single blank); other blanks are held and flushed before the next non-blank or
// at a line end. The tab width register (2 to MAX_TAB_WIDTH, wider or narrower
// values clamp, reset 8) is written on "cfg" and should change only while idle.
// Each accepted character goes through the command queue into the output
// register, which delivers one byte a cycle while out is ready; a character
// that flushes k held blanks gives k + 1 bytes, and input stalls once the
// two-entry command queue between classifier and expander fills.
module space_run_to_tab_compressor #(
    parameter int MAX_TAB_WIDTH = stc_pkg::MAX_TAB_WIDTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    stc_in_if.sink     in,
    stc_out_if.source  out,
    stc_cfg_if.sink    cfg
);

    localparam int CNT_W = $clog2(MAX_TAB_WIDTH);
    localparam int CMD_W = CNT_W + 1 + stc_pkg::CHAR_W;

    logic             push_valid;
    logic [CMD_W-1:0] push_data;
    logic             push_ready;
    logic             head_valid;
    logic [CMD_W-1:0] head_data;
    logic             pop;

    // classifier: column tracking and command generation
    stc_front #(
        .MAX_TAB_WIDTH (MAX_TAB_WIDTH),
        .CNT_W         (CNT_W),
        .CMD_W         (CMD_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in         (in),
        .cfg        (cfg),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready)
    );

    // command queue
    stc_cmd_fifo #(
        .DATA_W (CMD_W)
    ) u_cmd_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop)
    );

    // expander: emits blanks and characters
    stc_back #(
        .MAX_TAB_WIDTH (MAX_TAB_WIDTH),
        .CNT_W         (CNT_W),
        .CMD_W         (CMD_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop),
        .out        (out)
    );

endmodule
